// ===== rtl/core/lz4bd_pkg.sv =====
// ----------------------------------------------------------------------------
// lz4bd_pkg
// Shared types and constants of the LZ4 block decoder.
// ----------------------------------------------------------------------------
package lz4bd_pkg;

   localparam int unsigned BLOCK_BYTES_DEFAULT = 8192;
   localparam int unsigned LEN_W = 15;
   localparam logic [14:0] LEN_MAX = 15'h7fff;
   localparam logic [13:0] EXPECTED_RESET = 14'd8192;

   typedef enum logic [2:0] {
      PH_TOKEN    = 3'd0,
      PH_LITEXT   = 3'd1,
      PH_LIT      = 3'd2,
      PH_OFFLO    = 3'd3,
      PH_OFFHI    = 3'd4,
      PH_MATCHEXT = 3'd5,
      PH_COPY     = 3'd6,
      PH_DRAIN    = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_TRUNC_LEN = 3'd1,
      ERR_LIT_RANGE = 3'd2,
      ERR_TRUNC_OFF = 3'd3,
      ERR_BAD_OFF   = 3'd4,
      ERR_MATCH_OVF = 3'd5,
      ERR_SIZE      = 3'd6,
      ERR_MISUSE    = 3'd7
   } err_type;

   typedef enum logic {
      ACT_PUSH = 1'b0,
      ACT_PULL = 1'b1
   } act_type;

   // history write and read requests
   typedef struct packed {
      logic        wr_en;
      logic [16:0] wr_addr;
      logic [7:0]  wr_data;
      logic        rd_en;
      logic [16:0] rd_addr;
   } hist_req_type;

   function automatic logic [14:0] sat_add(input logic [14:0] a, input logic [14:0] b);
      logic [15:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15] ? LEN_MAX : s[14:0];
   endfunction

endpackage

// ===== rtl/core/lz4bd_history.sv =====
// ----------------------------------------------------------------------------
// lz4bd_history
// History store of decoded bytes, one write and one registered read port.
// ----------------------------------------------------------------------------
module lz4bd_history #(
   parameter int unsigned BLOCK_BYTES = lz4bd_pkg::BLOCK_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  lz4bd_pkg::hist_req_type req,
   output logic [7:0]             rd_data
);
   localparam int unsigned AW = $clog2(BLOCK_BYTES);

   logic [7:0] mem [BLOCK_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr[AW-1:0]] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/lz4_block_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// lz4_block_decoder_unit
// Streaming LZ4 block decoder with match history store.
// ----------------------------------------------------------------------------
// One request per cycle: a push decodes one compressed byte, a pull emits one
// match byte. Each request gives one response. A pull's byte comes from a
// synchronous history read, so responses appear in the cycle after
// acceptance through a single response stage, and requests follow back to
// back while the response side is ready. Every decoded byte is written to
// history in the cycle after its request; a pull whose source is that pending
// byte takes it from the write stage instead of the store.
// No clearing pass: entries are only read after being written in the block.
module lz4_block_decoder_unit #(
   parameter int unsigned BLOCK_BYTES = lz4bd_pkg::BLOCK_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [13:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_out_valid,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_copy_pending,
   output logic        rsp_block_done,
   output logic [2:0]  rsp_error_code
);
   localparam int unsigned AW = $clog2(BLOCK_BYTES);

   logic [13:0] expected_ff;
   lz4bd_pkg::phase_type phase_ff, phase_in;
   logic [16:0] produced_ff, produced_in;
   logic [14:0] lit_ff, lit_in, match_ff, match_in;
   logic [15:0] dist_ff, dist_in;
   logic [3:0]  nib_ff, nib_in;
   logic        last_ff, last_in;
   logic [2:0]  errh_ff, errh_in;

   // response stage
   logic        rv_ff;
   logic        ov_ff, ov_in;
   logic        use_mem_ff, use_mem_in;
   logic [7:0]  ob_ff, ob_in;
   logic        cp_ff, cp_in;
   logic        dn_ff, dn_in;
   logic [2:0]  ec_ff, ec_in;

   // history write stage
   logic        wp_ff, wp_in;
   logic        wm_ff, wm_in;
   logic [7:0]  wd_ff, wd_in;
   logic [16:0] wa_ff;

   lz4bd_pkg::hist_req_type hreq;
   logic [7:0] rd_data, cur_byte, fwd_data;
   logic       accept;
   logic       fwd_hit;
   logic [16:0] eff_exp;
   logic [16:0] src;

   assign req_ready = !rv_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign eff_exp = ({3'd0, expected_ff} > 17'(BLOCK_BYTES)) ? 17'(BLOCK_BYTES)
                                                             : {3'd0, expected_ff};
   assign cur_byte = use_mem_ff ? rd_data : ob_ff;
   assign src = produced_ff - {1'b0, dist_ff};
   assign fwd_data = wm_ff ? rd_data : wd_ff;
   assign fwd_hit = wp_ff && (wa_ff[AW-1:0] == src[AW-1:0]);

   lz4bd_history #(.BLOCK_BYTES(BLOCK_BYTES)) u_hist (
      .clock(clock), .req(hreq), .rd_data(rd_data));

   function automatic logic exceeds(input logic [16:0] p, input logic [16:0] e,
                                    input logic [14:0] len);
      return (p > e) || ({2'b0, len} > (e - p));
   endfunction

   always_comb begin
      logic [14:0] m;
      logic [15:0] d;
      logic        fail;
      logic [2:0]  fcode;
      logic        endb;
      logic        emit;
      phase_in = phase_ff; produced_in = produced_ff; lit_in = lit_ff;
      match_in = match_ff; dist_in = dist_ff; nib_in = nib_ff;
      last_in = last_ff; errh_in = errh_ff;
      ov_in = 1'b0; ob_in = 8'd0; use_mem_in = 1'b0; dn_in = 1'b0;
      ec_in = lz4bd_pkg::ERR_NONE;
      wp_in = 1'b0; wm_in = 1'b0; wd_in = 8'd0;
      fail = 1'b0; fcode = lz4bd_pkg::ERR_NONE; endb = 1'b0; emit = 1'b0;
      m = '0; d = '0;
      hreq = '0;
      hreq.wr_en = wp_ff;
      hreq.wr_addr = wa_ff;
      hreq.wr_data = fwd_data;
      hreq.rd_addr = {{(17-AW){1'b0}}, src[AW-1:0]};

      if (accept) begin
         if (phase_ff == lz4bd_pkg::PH_DRAIN) begin
            dn_in = 1'b1; ec_in = errh_ff;
            if (req_action == lz4bd_pkg::ACT_PUSH && req_in_last) begin
               phase_in = lz4bd_pkg::PH_TOKEN; errh_in = '0; produced_in = '0;
               lit_in = '0; match_in = '0; dist_in = '0; nib_in = '0; last_in = 1'b0;
            end
         end else if (phase_ff == lz4bd_pkg::PH_COPY) begin
            if (req_action == lz4bd_pkg::ACT_PUSH) begin
               fail = 1'b1; fcode = lz4bd_pkg::ERR_MISUSE;
            end else begin
               ov_in = 1'b1;
               if (fwd_hit) begin
                  use_mem_in = 1'b0; ob_in = fwd_data;
               end else begin
                  use_mem_in = 1'b1; hreq.rd_en = 1'b1;
               end
               emit = 1'b1;
               m = (match_ff > 15'd0) ? match_ff - 15'd1 : match_ff;
               match_in = m;
               if (m == 15'd0) begin
                  if (last_ff) endb = 1'b1;
                  else phase_in = lz4bd_pkg::PH_TOKEN;
               end
            end
         end else if (req_action == lz4bd_pkg::ACT_PULL) begin
            fail = 1'b1; fcode = lz4bd_pkg::ERR_MISUSE;
         end else begin
            last_in = req_in_last;
            case (phase_ff)
               lz4bd_pkg::PH_TOKEN, lz4bd_pkg::PH_LITEXT: begin
                  if (phase_ff == lz4bd_pkg::PH_TOKEN) begin
                     nib_in = req_in_byte[3:0];
                     m = {11'd0, req_in_byte[7:4]};
                  end else begin
                     m = lz4bd_pkg::sat_add(lit_ff, {7'd0, req_in_byte});
                  end
                  lit_in = m;
                  if ((phase_ff == lz4bd_pkg::PH_TOKEN && m == 15'd15) ||
                      (phase_ff == lz4bd_pkg::PH_LITEXT && req_in_byte == 8'hff)) begin
                     if (req_in_last) begin
                        fail = 1'b1; fcode = lz4bd_pkg::ERR_TRUNC_LEN;
                     end else phase_in = lz4bd_pkg::PH_LITEXT;
                  end else if (exceeds(produced_ff, eff_exp, m) ||
                               (m != 15'd0 && req_in_last)) begin
                     fail = 1'b1; fcode = lz4bd_pkg::ERR_LIT_RANGE;
                  end else if (m == 15'd0) begin
                     if (req_in_last) endb = 1'b1;
                     else phase_in = lz4bd_pkg::PH_OFFLO;
                  end else phase_in = lz4bd_pkg::PH_LIT;
               end
               lz4bd_pkg::PH_LIT: begin
                  if (req_in_last && lit_ff > 15'd1) begin
                     fail = 1'b1; fcode = lz4bd_pkg::ERR_LIT_RANGE;
                  end else begin
                     emit = 1'b1; ov_in = 1'b1; ob_in = req_in_byte;
                     lit_in = lit_ff - 15'd1;
                     if (lit_in == 15'd0) begin
                        if (req_in_last) endb = 1'b1;
                        else phase_in = lz4bd_pkg::PH_OFFLO;
                     end
                  end
               end
               lz4bd_pkg::PH_OFFLO: begin
                  if (req_in_last) begin
                     fail = 1'b1; fcode = lz4bd_pkg::ERR_TRUNC_OFF;
                  end else begin
                     dist_in = {8'd0, req_in_byte}; phase_in = lz4bd_pkg::PH_OFFHI;
                  end
               end
               lz4bd_pkg::PH_OFFHI: begin
                  d = {req_in_byte, dist_ff[7:0]};
                  dist_in = d;
                  if (d == 16'd0 || {1'b0, d} > produced_ff) begin
                     fail = 1'b1; fcode = lz4bd_pkg::ERR_BAD_OFF;
                  end else if (nib_ff == 4'hf) begin
                     match_in = 15'd15;
                     if (req_in_last) begin
                        fail = 1'b1; fcode = lz4bd_pkg::ERR_TRUNC_LEN;
                     end else phase_in = lz4bd_pkg::PH_MATCHEXT;
                  end else begin
                     m = lz4bd_pkg::sat_add({11'd0, nib_ff}, 15'd4);
                     if (exceeds(produced_ff, eff_exp, m)) begin
                        fail = 1'b1; fcode = lz4bd_pkg::ERR_MATCH_OVF;
                     end else begin
                        match_in = m; phase_in = lz4bd_pkg::PH_COPY;
                     end
                  end
               end
               lz4bd_pkg::PH_MATCHEXT: begin
                  match_in = lz4bd_pkg::sat_add(match_ff, {7'd0, req_in_byte});
                  if (req_in_byte == 8'hff) begin
                     if (req_in_last) begin
                        fail = 1'b1; fcode = lz4bd_pkg::ERR_TRUNC_LEN;
                     end
                  end else begin
                     m = lz4bd_pkg::sat_add(match_in, 15'd4);
                     if (exceeds(produced_ff, eff_exp, m)) begin
                        fail = 1'b1; fcode = lz4bd_pkg::ERR_MATCH_OVF;
                     end else begin
                        match_in = m; phase_in = lz4bd_pkg::PH_COPY;
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         if (emit) begin
            wp_in = 1'b1;
            wd_in = ob_in;
            wm_in = use_mem_in;
            produced_in = produced_ff + 17'd1;
         end
         if (fail) begin
            ov_in = 1'b0; ob_in = 8'd0; use_mem_in = 1'b0; dn_in = 1'b1; ec_in = fcode;
            wp_in = 1'b0; produced_in = produced_ff;
            if (phase_ff != lz4bd_pkg::PH_COPY && req_action == lz4bd_pkg::ACT_PULL) begin
               phase_in = lz4bd_pkg::PH_DRAIN; errh_in = fcode;
            end else if (req_in_last) begin
               phase_in = lz4bd_pkg::PH_TOKEN; produced_in = '0; lit_in = '0;
               match_in = '0; dist_in = '0; nib_in = '0; last_in = 1'b0; errh_in = '0;
            end else begin
               phase_in = lz4bd_pkg::PH_DRAIN; errh_in = fcode;
            end
         end
         if (endb) begin
            dn_in = 1'b1;
            ec_in = (produced_in != eff_exp) ? lz4bd_pkg::ERR_SIZE : lz4bd_pkg::ERR_NONE;
            phase_in = lz4bd_pkg::PH_TOKEN; produced_in = '0; lit_in = '0;
            match_in = '0; dist_in = '0; nib_in = '0; last_in = 1'b0; errh_in = '0;
         end
      end
      cp_in = (phase_in == lz4bd_pkg::PH_COPY);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= lz4bd_pkg::EXPECTED_RESET;
         phase_ff <= lz4bd_pkg::PH_TOKEN;
         produced_ff <= '0; lit_ff <= '0; match_ff <= '0; dist_ff <= '0;
         nib_ff <= '0; last_ff <= 1'b0; errh_ff <= '0; rv_ff <= 1'b0;
         wp_ff <= 1'b0; wm_ff <= 1'b0; wd_ff <= '0; wa_ff <= '0;
      end else begin
         if (csr_we) expected_ff <= csr_wdata;
         phase_ff <= phase_in; produced_ff <= produced_in; lit_ff <= lit_in;
         match_ff <= match_in; dist_ff <= dist_in; nib_ff <= nib_in;
         last_ff <= last_in; errh_ff <= errh_in;
         wp_ff <= wp_in; wm_ff <= wm_in; wd_ff <= wd_in; wa_ff <= produced_ff;
         if (accept) begin
            rv_ff <= 1'b1;
         end else if (rsp_ready) begin
            rv_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ov_ff <= ov_in; ob_ff <= ob_in; use_mem_ff <= use_mem_in;
         cp_ff <= cp_in; dn_ff <= dn_in; ec_ff <= ec_in;
      end else if (use_mem_ff) begin
         ob_ff <= rd_data; use_mem_ff <= 1'b0;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_out_valid = ov_ff;
   assign rsp_out_byte = cur_byte;
   assign rsp_copy_pending = cp_ff;
   assign rsp_block_done = dn_ff;
   assign rsp_error_code = ec_ff;

`ifndef NO_ASSERTIONS
   a_err_done: assert property (@(posedge clock) disable iff (reset)
      rv_ff && ec_ff != lz4bd_pkg::ERR_NONE |-> dn_ff) else $error("error without done");
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !ov_ff |-> cur_byte == 8'd0) else $error("byte not zero");
   a_drain_err: assert property (@(posedge clock) disable iff (reset)
      phase_ff == lz4bd_pkg::PH_DRAIN |-> errh_ff != lz4bd_pkg::ERR_NONE)
      else $error("drain without error");
   a_prod_bound: assert property (@(posedge clock) disable iff (reset)
      produced_ff <= 17'(BLOCK_BYTES)) else $error("produced overflow");
`endif

endmodule

// ===== tb/tb_lz4_block_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_lz4_block_decoder_unit
// Self-checking bench for the streaming LZ4 block decoder.
// ----------------------------------------------------------------------------
// Well-formed LZ4 blocks with random content are pushed, together with the
// pulls that drain each match. Corrupted blocks, random noise and directed
// error cases are mixed in. A scoreboard class keeps its own decoder state
// and history store and predicts every response. Both handshake sides idle at
// random in several phases, and the response side holds off once for a long
// stretch so that the decoder backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_lz4_block_decoder_unit;

   localparam int unsigned HIST_BYTES = lz4bd_pkg::BLOCK_BYTES_DEFAULT;
   localparam int unsigned CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic               out_valid;
      logic [7:0]         out_byte;
      logic               copy_pending;
      logic               block_done;
      lz4bd_pkg::err_type code;
   } decoded_type;

   typedef struct {
      lz4bd_pkg::act_type act;
      logic [7:0]         data;
      logic               last;
   } request_type;

   class decode_scoreboard;
      int unsigned          limit_bytes;
      lz4bd_pkg::phase_type ph;
      logic [7:0]           hist [HIST_BYTES];
      int unsigned          produced, lit_left, match_left, distance, nibble;
      logic                 last_seen;
      lz4bd_pkg::err_type   held;
      decoded_type          expected_q [$];
      decoded_type          r;
      int unsigned          accepted;
      int unsigned          mismatches;

      function new();
         limit_bytes = 8192;
         accepted = 0;
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         ph = lz4bd_pkg::PH_TOKEN;
         produced = 0;
         lit_left = 0;
         match_left = 0;
         distance = 0;
         nibble = 0;
         last_seen = 0;
         held = lz4bd_pkg::ERR_NONE;
      endfunction

      function int unsigned eff();
         return (limit_bytes > HIST_BYTES) ? HIST_BYTES : limit_bytes;
      endfunction

      function int unsigned sat(int unsigned a, int unsigned b);
         return (a + b > 32767) ? 32767 : a + b;
      endfunction

      function bit no_room(int unsigned len);
         return produced > eff() || len > eff() - produced;
      endfunction

      function void fail(lz4bd_pkg::err_type code, logic last);
         r.out_valid = 0;
         r.out_byte = 0;
         r.block_done = 1;
         r.code = code;
         if (last) begin
            restart();
         end else begin
            ph = lz4bd_pkg::PH_DRAIN;
            held = code;
         end
      endfunction

      function void end_block();
         r.block_done = 1;
         r.code = (produced != eff()) ? lz4bd_pkg::ERR_SIZE : lz4bd_pkg::ERR_NONE;
         restart();
      endfunction

      function void emit(logic [7:0] b);
         hist[produced % HIST_BYTES] = b;
         produced++;
         r.out_valid = 1;
         r.out_byte = b;
      endfunction

      function void literals_known(logic last);
         if (no_room(lit_left)) fail(lz4bd_pkg::ERR_LIT_RANGE, last);
         else if (lit_left == 0) begin
            if (last) end_block();
            else ph = lz4bd_pkg::PH_OFFLO;
         end else if (last) fail(lz4bd_pkg::ERR_LIT_RANGE, last);
         else ph = lz4bd_pkg::PH_LIT;
      endfunction

      function void match_known(logic last);
         int unsigned m;
         m = sat(match_left, 4);
         if (no_room(m)) fail(lz4bd_pkg::ERR_MATCH_OVF, last);
         else begin
            match_left = m;
            ph = lz4bd_pkg::PH_COPY;
         end
      endfunction

      function void push_byte(logic [7:0] b, logic last);
         last_seen = last;
         case (ph)
            lz4bd_pkg::PH_TOKEN: begin
               nibble = b[3:0];
               lit_left = b[7:4];
               if (lit_left == 15) begin
                  if (last) fail(lz4bd_pkg::ERR_TRUNC_LEN, last);
                  else ph = lz4bd_pkg::PH_LITEXT;
               end else literals_known(last);
            end
            lz4bd_pkg::PH_LITEXT: begin
               lit_left = sat(lit_left, b);
               if (b == 8'hff) begin
                  if (last) fail(lz4bd_pkg::ERR_TRUNC_LEN, last);
               end else literals_known(last);
            end
            lz4bd_pkg::PH_LIT: begin
               if (last && lit_left > 1) fail(lz4bd_pkg::ERR_LIT_RANGE, last);
               else begin
                  emit(b);
                  lit_left--;
                  if (lit_left == 0) begin
                     if (last) end_block();
                     else ph = lz4bd_pkg::PH_OFFLO;
                  end
               end
            end
            lz4bd_pkg::PH_OFFLO: begin
               if (last) fail(lz4bd_pkg::ERR_TRUNC_OFF, last);
               else begin
                  distance = b;
                  ph = lz4bd_pkg::PH_OFFHI;
               end
            end
            lz4bd_pkg::PH_OFFHI: begin
               distance = distance | (int'(b) << 8);
               if (distance == 0 || distance > produced) fail(lz4bd_pkg::ERR_BAD_OFF, last);
               else if (nibble == 15) begin
                  match_left = 15;
                  if (last) fail(lz4bd_pkg::ERR_TRUNC_LEN, last);
                  else ph = lz4bd_pkg::PH_MATCHEXT;
               end else begin
                  match_left = nibble;
                  match_known(last);
               end
            end
            default: begin
               match_left = sat(match_left, b);
               if (b == 8'hff) begin
                  if (last) fail(lz4bd_pkg::ERR_TRUNC_LEN, last);
               end else match_known(last);
            end
         endcase
      endfunction

      function void pull_byte();
         emit(hist[(produced - distance) % HIST_BYTES]);
         if (match_left > 0) match_left--;
         if (match_left == 0) begin
            if (last_seen) end_block();
            else ph = lz4bd_pkg::PH_TOKEN;
         end
      endfunction

      function void note_request(lz4bd_pkg::act_type a, logic [7:0] b, logic last);
         r = '0;
         accepted++;
         if (ph == lz4bd_pkg::PH_DRAIN) begin
            r.block_done = 1;
            r.code = held;
            if (a == lz4bd_pkg::ACT_PUSH && last) restart();
         end else if (ph == lz4bd_pkg::PH_COPY) begin
            if (a == lz4bd_pkg::ACT_PUSH) fail(lz4bd_pkg::ERR_MISUSE, last);
            else pull_byte();
         end else if (a == lz4bd_pkg::ACT_PULL) fail(lz4bd_pkg::ERR_MISUSE, 1'b0);
         else push_byte(b, last);
         r.copy_pending = (ph == lz4bd_pkg::PH_COPY);
         expected_q.insert(expected_q.size(), r);
      endfunction

      function void check_response(decoded_type got);
         decoded_type exp;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
         end else begin
            exp = expected_q.pop_front();
            if (got.out_valid !== exp.out_valid || got.out_byte !== exp.out_byte ||
                got.copy_pending !== exp.copy_pending ||
                got.block_done !== exp.block_done || got.code !== exp.code) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: expected %p got %p", $realtime, exp, got);
            end
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               csr_we = 0;
   logic [13:0]        csr_wdata = '0;
   logic               req_valid = 0;
   logic               req_ready;
   lz4bd_pkg::act_type req_action = lz4bd_pkg::ACT_PUSH;
   logic [7:0]         req_in_byte = '0;
   logic               req_in_last = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic               rsp_out_valid;
   logic [7:0]         rsp_out_byte;
   logic               rsp_copy_pending;
   logic               rsp_block_done;
   logic [2:0]         rsp_error_code;

   decode_scoreboard sb = new();
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_cycles = 0;

   lz4_block_decoder_unit DUT (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_in_byte(req_in_byte), .req_in_last(req_in_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_valid(rsp_out_valid), .rsp_out_byte(rsp_out_byte),
      .rsp_copy_pending(rsp_copy_pending), .rsp_block_done(rsp_block_done),
      .rsp_error_code(rsp_error_code)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      int unsigned cyc;
      cyc = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // response side: check, then pick next ready
   initial begin
      decoded_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.out_valid = rsp_out_valid;
            got.out_byte = rsp_out_byte;
            got.copy_pending = rsp_copy_pending;
            got.block_done = rsp_block_done;
            got.code = lz4bd_pkg::err_type'(rsp_error_code);
            sb.check_response(got);
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send(lz4bd_pkg::act_type a, logic [7:0] b, logic last);
      int unsigned gap;
      req_valid <= 1;
      req_action <= a;
      req_in_byte <= b;
      req_in_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(a, b, last);
      gap = 0;
      if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic set_expected_bytes(logic [13:0] v);
      req_valid <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      sb.limit_bytes = v;
   endtask

   // bring the decoder back to the token phase
   task automatic resync();
      while (sb.ph != lz4bd_pkg::PH_TOKEN) begin
         if (sb.ph == lz4bd_pkg::PH_COPY)
            send(lz4bd_pkg::ACT_PULL, 8'($urandom), 1'($urandom));
         else send(lz4bd_pkg::ACT_PUSH, 8'($urandom), 1'b1);
      end
   endtask

   task automatic add_ext(ref request_type q [$], input int unsigned v);
      request_type it;
      it.act = lz4bd_pkg::ACT_PUSH;
      it.last = 0;
      while (v >= 255) begin
         it.data = 8'hff;
         q.insert(q.size(), it);
         v -= 255;
      end
      it.data = v[7:0];
      q.insert(q.size(), it);
   endtask

   task automatic run_block(int unsigned e, int unsigned cap, bit broken);
      request_type items [$];
      request_type it;
      int unsigned made, rem, lit, mlen, offs, k, top;
      bit ends_on_match;
      made = 0;
      it.last = 0;
      do begin
         rem = e - made;
         top = (rem < cap) ? rem : cap;
         lit = $urandom_range(made == 0 ? 1 : 0, top < 1 ? 1 : top);
         if (lit > rem) lit = rem;
         mlen = 0;
         if (rem - lit >= 4 && $urandom_range(3) != 0) begin
            top = (rem - lit < cap) ? rem - lit : cap;
            mlen = $urandom_range(4, top < 4 ? 4 : top);
         end else lit = rem;
         it.act = lz4bd_pkg::ACT_PUSH;
         it.data = {(lit >= 15) ? 4'hf : lit[3:0],
                    (mlen == 0) ? 4'h0 : ((mlen - 4 >= 15) ? 4'hf : 4'(mlen - 4))};
         items.insert(items.size(), it);
         if (lit >= 15) add_ext(items, lit - 15);
         repeat (lit) begin
            it.data = 8'($urandom);
            items.insert(items.size(), it);
         end
         made += lit;
         ends_on_match = (mlen != 0);
         if (mlen != 0) begin
            top = (made < 16 || $urandom_range(1) == 0) ? made : 16;
            offs = $urandom_range(1, top);
            it.data = offs[7:0];
            items.insert(items.size(), it);
            it.data = offs[15:8];
            items.insert(items.size(), it);
            if (mlen - 4 >= 15) add_ext(items, mlen - 19);
            it.act = lz4bd_pkg::ACT_PULL;
            repeat (mlen) begin
               it.data = 8'($urandom);
               items.insert(items.size(), it);
            end
            made += mlen;
         end
      end while (made < e || (ends_on_match && $urandom_range(1) == 0));
      for (int i = items.size() - 1; i >= 0; i--) begin
         if (items[i].act == lz4bd_pkg::ACT_PUSH) begin
            items[i].last = 1;
            break;
         end
      end
      if (broken) begin
         k = $urandom_range(0, items.size() - 1);
         case ($urandom_range(2))
            0: items[k].data = 8'($urandom);
            1: begin
               items = items[0:k];
               items[k].last = 1;
            end
            default: begin
               it.act = lz4bd_pkg::act_type'($urandom_range(1));
               it.data = 8'($urandom);
               it.last = 1'($urandom_range(1));
               items.insert(k, it);
            end
         endcase
      end
      foreach (items[i]) send(items[i].act, items[i].data, items[i].last);
      resync();
   endtask

   initial begin
      int unsigned target, e;
      int unsigned idle_tab [4];
      int unsigned stall_tab [4];
      idle_tab = '{0, 67, 0, 20};
      stall_tab = '{0, 0, 67, 20};
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: error paths
      set_expected_bytes(14'd16);
      send(lz4bd_pkg::ACT_PULL, 8'h00, 1'b0);
      send(lz4bd_pkg::ACT_PUSH, 8'h00, 1'b1);
      send(lz4bd_pkg::ACT_PUSH, 8'hf0, 1'b1);
      send(lz4bd_pkg::ACT_PUSH, 8'h10, 1'b0);
      send(lz4bd_pkg::ACT_PUSH, 8'haa, 1'b0);
      send(lz4bd_pkg::ACT_PUSH, 8'h01, 1'b1);
      send(lz4bd_pkg::ACT_PUSH, 8'h10, 1'b0);
      send(lz4bd_pkg::ACT_PUSH, 8'h55, 1'b0);
      send(lz4bd_pkg::ACT_PUSH, 8'h00, 1'b0);
      send(lz4bd_pkg::ACT_PUSH, 8'h00, 1'b0);
      send(lz4bd_pkg::ACT_PULL, 8'h00, 1'b0);
      send(lz4bd_pkg::ACT_PUSH, 8'h00, 1'b1);
      send(lz4bd_pkg::ACT_PUSH, 8'h30, 1'b0);
      send(lz4bd_pkg::ACT_PUSH, 8'h01, 1'b0);
      send(lz4bd_pkg::ACT_PUSH, 8'h02, 1'b1);
      send(lz4bd_pkg::ACT_PUSH, 8'h10, 1'b0);
      send(lz4bd_pkg::ACT_PUSH, 8'hff, 1'b0);
      send(lz4bd_pkg::ACT_PUSH, 8'h01, 1'b0);
      send(lz4bd_pkg::ACT_PUSH, 8'h00, 1'b0);
      send(lz4bd_pkg::ACT_PUSH, 8'h00, 1'b0);
      send(lz4bd_pkg::ACT_PUSH, 8'h00, 1'b1);
      send(lz4bd_pkg::ACT_PUSH, 8'h00, 1'b1);
      resync();

      // length counters saturating, literal and match
      set_expected_bytes(14'd8192);
      send(lz4bd_pkg::ACT_PUSH, 8'hf0, 1'b0);
      repeat (130) send(lz4bd_pkg::ACT_PUSH, 8'hff, 1'b0);
      send(lz4bd_pkg::ACT_PUSH, 8'h00, 1'b0);
      send(lz4bd_pkg::ACT_PUSH, 8'h00, 1'b1);
      send(lz4bd_pkg::ACT_PUSH, 8'h1f, 1'b0);
      send(lz4bd_pkg::ACT_PUSH, 8'h5a, 1'b0);
      send(lz4bd_pkg::ACT_PUSH, 8'h01, 1'b0);
      send(lz4bd_pkg::ACT_PUSH, 8'h00, 1'b0);
      repeat (130) send(lz4bd_pkg::ACT_PUSH, 8'hff, 1'b0);
      send(lz4bd_pkg::ACT_PUSH, 8'h00, 1'b0);
      send(lz4bd_pkg::ACT_PUSH, 8'h00, 1'b1);
      resync();

      // size extremes
      set_expected_bytes(14'd1);
      run_block(1, 20, 0);
      run_block(1, 20, 0);
      set_expected_bytes(14'd16383);
      run_block(100, 700, 0);

      // long receiver hold while requests keep coming
      set_expected_bytes(14'd200);
      hold_cycles = 400;
      run_block(200, 40, 0);

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_tab[p];
         stall_pct = stall_tab[p];
         target = sb.accepted + 225;
         e = sb.limit_bytes;
         while (sb.accepted < target) begin
            if ($urandom_range(2) == 0) begin
               e = ($urandom_range(9) == 0) ? $urandom_range(1, 16383) : $urandom_range(1, 48);
               set_expected_bytes(e[13:0]);
            end
            if ($urandom_range(9) == 0) begin
               repeat ($urandom_range(1, 8))
                  send(lz4bd_pkg::act_type'($urandom_range(1)), 8'($urandom), 1'($urandom));
               resync();
            end else if (e > 64) begin
               run_block(64, 20, 1'($urandom_range(1)));
            end else begin
               run_block(e, 20, ($urandom_range(4) == 0));
            end
         end
      end

      req_valid <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
